// File: rtl/assert_macros.svh
// Assertion helpers for the RTL; alpha_block_palette_encoder.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// The expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`endif

// File: rtl/abpe_pkg.sv
package abpe_pkg;

    localparam int MAX_RESULTS  = 4;
    localparam int RESULT_IDX_W = 2;
    localparam int COUNT_W      = 3;
    localparam int PALETTE_ENTRIES = 16;

    localparam logic [2:0] GROUP_PIXELS = 3'd4;
    localparam logic [7:0] ALPHA_ZERO   = 8'h00;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [3:0] MISS_INDEX   = 4'hF;

    // Stream codes on the result channel.
    localparam logic STREAM_FLAG  = 1'b0;
    localparam logic STREAM_INDEX = 1'b1;

    // Configuration register indexes.
    localparam logic REG_PALETTE_LOW  = 1'b0;
    localparam logic REG_PALETTE_HIGH = 1'b1;

    typedef struct packed {
        logic [7:0] pixel0;
        logic [7:0] pixel1;
        logic [7:0] pixel2;
        logic [7:0] pixel3;
        logic [2:0] pixel_count;
        logic       end_of_image;
    } abpe_group_t;

    typedef struct packed {
        logic       stream_select;
        logic [7:0] data_byte;
        logic       palette_miss;
        logic       run_last;
        logic       image_last;
    } abpe_result_t;

    typedef abpe_result_t [MAX_RESULTS-1:0] abpe_result_list_t;

    typedef struct packed {
        abpe_result_list_t    results;
        logic [COUNT_W-1:0]   count;
        logic [7:0]           next_acc;
        logic [2:0]           next_fill;
    } abpe_enc_t;

    typedef struct packed {
        logic [3:0] index;
        logic       miss;
    } abpe_lookup_t;

    // First palette entry equal to the value; a miss gives the last index.
    function automatic abpe_lookup_t palette_lookup(input logic [7:0] value,
                                                    input logic [63:0] pal_low,
                                                    input logic [63:0] pal_high);
        abpe_lookup_t r;
        logic [127:0] pal;
        r.index = MISS_INDEX;
        r.miss  = 1'b1;
        pal = {pal_high, pal_low};
        for (int i = PALETTE_ENTRIES - 1; i >= 0; i--)
        begin
            if (pal[8*i +: 8] == value)
            begin
                r.index = 4'(i);
                r.miss  = 1'b0;
            end
        end
        return r;
    endfunction

endpackage

// File: rtl/abpe_group_if.sv
interface abpe_group_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel0;
    logic [7:0] pixel1;
    logic [7:0] pixel2;
    logic [7:0] pixel3;
    logic [2:0] pixel_count;
    logic       end_of_image;

    modport source (
        output valid, pixel0, pixel1, pixel2, pixel3, pixel_count, end_of_image,
        input  ready
    );
    modport sink (
        input  valid, pixel0, pixel1, pixel2, pixel3, pixel_count, end_of_image,
        output ready
    );
endinterface

// File: rtl/abpe_result_if.sv
interface abpe_result_if;
    logic       valid;
    logic       ready;
    logic       stream_select;
    logic [7:0] data_byte;
    logic       palette_miss;
    logic       run_last;
    logic       image_last;

    modport source (
        output valid, stream_select, data_byte, palette_miss, run_last, image_last,
        input  ready
    );
    modport sink (
        input  valid, stream_select, data_byte, palette_miss, run_last, image_last,
        output ready
    );
endinterface

// File: rtl/alpha_block_palette_encoder.sv
// Alpha block palette encoder.
// group_ch carries groups of four alpha values with a pixel count and an
// end-of-image mark; result_ch carries bytes of the flag stream
// (stream_select low) and of the palette index stream (stream_select high).
// Both are valid/ready channels; an item moves when valid and ready are high.
// The palette is written through cfg_we/cfg_index/cfg_data; the user must
// write it only while idle, as the block itself does not enforce this.
// An accepted group sits in an input register and is encoded in one pass
// once the result buffer is empty or hands over its last byte; its zero to
// four result bytes then load that buffer, which offers them in order and
// drains one byte per cycle while result_ch is ready. A noisy group makes
// two to four bytes. The input register refills while the buffer drains, so
// groups follow each other without gaps.
// When result_ch stalls, the buffer holds its byte, the input register holds
// the next group and group_ch.ready drops once both are full.
// Reset clears the palette, the flag accumulator and all valid state; no
// clearing pass is needed.
`include "assert_macros.svh"

module alpha_block_palette_encoder (
    input  logic                 clk,
    input  logic                 rst_n,
    abpe_group_if.sink           group_ch,
    abpe_result_if.source        result_ch,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [63:0]          cfg_data
);

    logic [63:0]                         pal_low_reg;
    logic [63:0]                         pal_high_reg;
    logic [7:0]                          flag_acc_reg;
    logic [2:0]                          flag_fill_reg;
    logic                                s1_valid_reg;
    abpe_pkg::abpe_group_t               s1_item_reg;
    logic                                buf_valid_reg;
    abpe_pkg::abpe_result_list_t         buf_res_reg;
    logic [abpe_pkg::COUNT_W-1:0]        buf_count_reg;
    logic [abpe_pkg::RESULT_IDX_W-1:0]   buf_ptr_reg;

    abpe_pkg::abpe_enc_t                 enc;
    abpe_pkg::abpe_result_t              cur;
    logic                                buf_last;
    logic                                buf_done;
    logic                                s1_move;
    logic                                in_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pal_low_reg  <= '0;
            pal_high_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                abpe_pkg::REG_PALETTE_LOW:  pal_low_reg  <= cfg_data;
                abpe_pkg::REG_PALETTE_HIGH: pal_high_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    abpe_group_encoder u_enc (
        .item      (s1_item_reg),
        .flag_acc  (flag_acc_reg),
        .flag_fill (flag_fill_reg),
        .pal_low   (pal_low_reg),
        .pal_high  (pal_high_reg),
        .enc       (enc)
    );

    assign cur      = buf_res_reg[buf_ptr_reg];
    assign buf_last = ({1'b0, buf_ptr_reg} == (buf_count_reg - 3'd1));
    assign buf_done = buf_valid_reg && result_ch.ready && buf_last;
    assign s1_move  = s1_valid_reg && (!buf_valid_reg || buf_done);
    assign in_take  = group_ch.valid && group_ch.ready;

    assign group_ch.ready = !s1_valid_reg || s1_move;

    assign result_ch.valid         = buf_valid_reg;
    assign result_ch.stream_select = cur.stream_select;
    assign result_ch.data_byte     = cur.data_byte;
    assign result_ch.palette_miss  = cur.palette_miss;
    assign result_ch.run_last      = cur.run_last;
    assign result_ch.image_last    = cur.image_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            buf_valid_reg <= 1'b0;
            buf_count_reg <= '0;
            buf_ptr_reg   <= '0;
            flag_acc_reg  <= '0;
            flag_fill_reg <= '0;
        end
        else
        begin
            if (in_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_move)
            begin
                // A group that produces no byte only updates the flag state.
                buf_valid_reg <= (enc.count != 3'd0);
                buf_count_reg <= enc.count;
                buf_ptr_reg   <= '0;
                flag_acc_reg  <= enc.next_acc;
                flag_fill_reg <= enc.next_fill;
            end
            else if (buf_done)
            begin
                buf_valid_reg <= 1'b0;
            end
            else if (buf_valid_reg && result_ch.ready)
            begin
                buf_ptr_reg <= buf_ptr_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_item_reg.pixel0       <= group_ch.pixel0;
            s1_item_reg.pixel1       <= group_ch.pixel1;
            s1_item_reg.pixel2       <= group_ch.pixel2;
            s1_item_reg.pixel3       <= group_ch.pixel3;
            s1_item_reg.pixel_count  <= group_ch.pixel_count;
            s1_item_reg.end_of_image <= group_ch.end_of_image;
        end
        if (s1_move)
        begin
            buf_res_reg <= enc.results;
        end
    end

    // The read pointer never passes the number of loaded bytes.
    `ASSERT_NEVER(a_ptr_in_range, clk, rst_n,
        buf_valid_reg && ({1'b0, buf_ptr_reg} >= buf_count_reg))

    // The byte marked as the end of its group is exactly the last one loaded.
    `ASSERT_ALWAYS(a_run_last_pos, clk, rst_n,
        buf_valid_reg |-> (result_ch.run_last == buf_last))

    // An end-of-image group leaves the flag state cleared.
    `ASSERT_ALWAYS(a_eoi_clears, clk, rst_n,
        (s1_move && s1_item_reg.end_of_image) |=>
            (flag_fill_reg == 3'd0 && flag_acc_reg == 8'h00))

endmodule

// File: rtl/abpe_group_encoder.sv
// Encodes one group against the current flag state and produces the list of
// result bytes it causes, in order, together with the next flag state.
module abpe_group_encoder (
    input  abpe_pkg::abpe_group_t item,
    input  logic [7:0]            flag_acc,
    input  logic [2:0]            flag_fill,
    input  logic [63:0]           pal_low,
    input  logic [63:0]           pal_high,
    output abpe_pkg::abpe_enc_t   enc
);

    abpe_pkg::abpe_lookup_t lk0;
    abpe_pkg::abpe_lookup_t lk1;
    abpe_pkg::abpe_lookup_t lk2;
    abpe_pkg::abpe_lookup_t lk3;

    assign lk0 = abpe_pkg::palette_lookup(item.pixel0, pal_low, pal_high);
    assign lk1 = abpe_pkg::palette_lookup(item.pixel1, pal_low, pal_high);
    assign lk2 = abpe_pkg::palette_lookup(item.pixel2, pal_low, pal_high);
    assign lk3 = abpe_pkg::palette_lookup(item.pixel3, pal_low, pal_high);

    always_comb
    begin
        logic [2:0]                          cnt;
        logic [2:0]                          pix_n;
        logic                                full;
        logic                                same;
        logic                                zero_grp;
        logic                                opaque_grp;
        logic [1:0]                          nbits;
        logic                                bit0;
        logic                                bit1;
        logic [7:0]                          acc;
        logic [3:0]                          fill;
        logic                                flag_done;
        logic [7:0]                          flag_byte;
        logic [abpe_pkg::COUNT_W-1:0]        n;
        abpe_pkg::abpe_result_t              r;
        abpe_pkg::abpe_result_list_t         res;

        r    = '0;
        cnt  = (item.pixel_count > abpe_pkg::GROUP_PIXELS) ? abpe_pkg::GROUP_PIXELS
                                                           : item.pixel_count;
        full = (cnt == abpe_pkg::GROUP_PIXELS);
        same = (item.pixel0 == item.pixel1) && (item.pixel1 == item.pixel2) &&
               (item.pixel2 == item.pixel3);
        zero_grp   = full && same && (item.pixel0 == abpe_pkg::ALPHA_ZERO);
        opaque_grp = full && same && (item.pixel0 == abpe_pkg::ALPHA_OPAQUE);

        nbits = 2'd0;
        bit0  = 1'b0;
        bit1  = 1'b0;
        if (zero_grp)
        begin
            nbits = 2'd1;
        end
        else if (opaque_grp)
        begin
            nbits = 2'd2;
            bit0  = 1'b1;
        end
        else if (full)
        begin
            nbits = 2'd2;
            bit0  = 1'b1;
            bit1  = 1'b1;
        end
        pix_n = (zero_grp || opaque_grp) ? 3'd0 : cnt;

        // At most two flag bits per group, so at most one flag byte completes.
        acc       = flag_acc;
        fill      = {1'b0, flag_fill};
        flag_done = 1'b0;
        flag_byte = 8'h00;
        if (nbits != 2'd0)
        begin
            acc  = acc | (8'(bit0) << fill[2:0]);
            fill = fill + 4'd1;
            if (fill[3])
            begin
                flag_done = 1'b1;
                flag_byte = acc;
                acc       = 8'h00;
                fill      = 4'd0;
            end
        end
        if (nbits == 2'd2)
        begin
            acc  = acc | (8'(bit1) << fill[2:0]);
            fill = fill + 4'd1;
            if (fill[3])
            begin
                flag_done = 1'b1;
                flag_byte = acc;
                acc       = 8'h00;
                fill      = 4'd0;
            end
        end

        res = '0;
        n   = '0;
        if (flag_done)
        begin
            r = '0;
            r.stream_select = abpe_pkg::STREAM_FLAG;
            r.data_byte     = flag_byte;
            res[n[1:0]]     = r;
            n = n + 3'd1;
        end
        if (pix_n != 3'd0)
        begin
            r = '0;
            r.stream_select = abpe_pkg::STREAM_INDEX;
            r.data_byte     = {(pix_n >= 3'd2) ? lk1.index : 4'h0, lk0.index};
            r.palette_miss  = lk0.miss | ((pix_n >= 3'd2) & lk1.miss);
            res[n[1:0]]     = r;
            n = n + 3'd1;
        end
        if (pix_n > 3'd2)
        begin
            r = '0;
            r.stream_select = abpe_pkg::STREAM_INDEX;
            r.data_byte     = {(pix_n == 3'd4) ? lk3.index : 4'h0, lk2.index};
            r.palette_miss  = lk2.miss | ((pix_n == 3'd4) & lk3.miss);
            res[n[1:0]]     = r;
            n = n + 3'd1;
        end
        if (item.end_of_image && (fill != 4'd0))
        begin
            r = '0;
            r.stream_select = abpe_pkg::STREAM_FLAG;
            r.data_byte     = acc;
            res[n[1:0]]     = r;
            n = n + 3'd1;
        end
        if (n != 3'd0)
        begin
            res[n[1:0] - 2'd1].run_last   = 1'b1;
            res[n[1:0] - 2'd1].image_last = item.end_of_image;
        end

        enc.results   = res;
        enc.count     = n;
        enc.next_acc  = item.end_of_image ? 8'h00 : acc;
        enc.next_fill = item.end_of_image ? 3'd0 : fill[2:0];
    end

endmodule

// File: dv/alpha_block_palette_encoder_tb.sv
module alpha_block_palette_encoder_tb;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 56;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [63:0] cfg_data;

    abpe_group_if  group_ch();
    abpe_result_if result_ch();

    alpha_block_palette_encoder uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .group_ch  (group_ch),
        .result_ch (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Palette and flag accumulator as the block should hold them.
    logic [63:0] pal_lo;
    logic [63:0] pal_hi;
    logic [7:0]  flag_bits;
    int          flag_count;

    abpe_pkg::abpe_group_t  pending_groups[$];
    abpe_pkg::abpe_result_t expected_bytes[$];

    bit steady;
    int mismatches;
    int cycle_count;
    int groups_accepted;
    int bytes_checked;
    int flag_bytes;
    int miss_bytes;
    int palettes_used;
    int stim_count;

    always #5 clk = ~clk;

    function automatic bit take_break();
        return !steady && ($urandom_range(99) < 28);
    endfunction

    // Returns {miss, index}: the first palette entry equal to the value.
    function automatic logic [4:0] find_entry(input logic [7:0] value);
        logic [127:0] pal;
        pal = {pal_hi, pal_lo};
        for (int i = 0; i < abpe_pkg::PALETTE_ENTRIES; i++)
        begin
            if (pal[8*i +: 8] == value)
                return {1'b0, 4'(i)};
        end
        return {1'b1, abpe_pkg::MISS_INDEX};
    endfunction

    function automatic void push_flag(input logic bit_value,
                                      ref abpe_pkg::abpe_result_t made[$]);
        flag_bits[flag_count] = bit_value;
        flag_count++;
        if (flag_count == 8)
        begin
            made.push_back('{stream_select: abpe_pkg::STREAM_FLAG, data_byte: flag_bits,
                             palette_miss: 1'b0, run_last: 1'b0, image_last: 1'b0});
            flag_bits  = '0;
            flag_count = 0;
        end
    endfunction

    function automatic void encode_group(input abpe_pkg::abpe_group_t g);
        logic [7:0]             px [4];
        logic [4:0]             lo;
        logic [4:0]             hi;
        int unsigned            cnt;
        bit                     same;
        abpe_pkg::abpe_result_t made[$];
        px[0] = g.pixel0;
        px[1] = g.pixel1;
        px[2] = g.pixel2;
        px[3] = g.pixel3;
        cnt = (g.pixel_count > abpe_pkg::GROUP_PIXELS) ? 4 : g.pixel_count;
        if (cnt == 4)
        begin
            same = (px[0] == px[1]) && (px[1] == px[2]) && (px[2] == px[3]);
            if (same && px[0] == abpe_pkg::ALPHA_ZERO)
            begin
                push_flag(1'b0, made);
                cnt = 0;
            end
            else if (same && px[0] == abpe_pkg::ALPHA_OPAQUE)
            begin
                push_flag(1'b1, made);
                push_flag(1'b0, made);
                cnt = 0;
            end
            else
            begin
                push_flag(1'b1, made);
                push_flag(1'b1, made);
            end
        end
        for (int i = 0; i < cnt; i += 2)
        begin
            lo = find_entry(px[i]);
            // An odd trailing nibble leaves the high nibble at zero.
            hi = (i + 1 < cnt) ? find_entry(px[i+1]) : 5'b0;
            made.push_back('{stream_select: abpe_pkg::STREAM_INDEX,
                             data_byte: {hi[3:0], lo[3:0]},
                             palette_miss: lo[4] | hi[4], run_last: 1'b0,
                             image_last: 1'b0});
        end
        if (g.end_of_image)
        begin
            if (flag_count != 0)
                made.push_back('{stream_select: abpe_pkg::STREAM_FLAG, data_byte: flag_bits,
                                 palette_miss: 1'b0, run_last: 1'b0, image_last: 1'b0});
            flag_bits  = '0;
            flag_count = 0;
        end
        if (made.size() > 0)
        begin
            made[made.size()-1].run_last   = 1'b1;
            made[made.size()-1].image_last = g.end_of_image;
        end
        foreach (made[k])
            expected_bytes.push_back(made[k]);
    endfunction

    function automatic abpe_pkg::abpe_group_t grp(input logic [7:0] p0, input logic [7:0] p1,
                                                  input logic [7:0] p2, input logic [7:0] p3,
                                                  input logic [2:0] cnt, input logic eoi);
        return '{pixel0: p0, pixel1: p1, pixel2: p2, pixel3: p3,
                 pixel_count: cnt, end_of_image: eoi};
    endfunction

    // Mostly values that sit in the palette, with some misses and extremes.
    function automatic logic [7:0] pick_alpha();
        logic [127:0] pal;
        pal = {pal_hi, pal_lo};
        case ($urandom_range(9))
            0:       return abpe_pkg::ALPHA_ZERO;
            1:       return abpe_pkg::ALPHA_OPAQUE;
            2, 3:    return 8'($urandom_range(255));
            default: return pal[8*$urandom_range(15) +: 8];
        endcase
    endfunction

    function automatic abpe_pkg::abpe_group_t random_group(input bit last);
        abpe_pkg::abpe_group_t g;
        int                    kind;
        kind = $urandom_range(9);
        if (kind < 3)
            g = grp(abpe_pkg::ALPHA_ZERO, abpe_pkg::ALPHA_ZERO, abpe_pkg::ALPHA_ZERO,
                    abpe_pkg::ALPHA_ZERO, abpe_pkg::GROUP_PIXELS, last);
        else if (kind < 5)
            g = grp(abpe_pkg::ALPHA_OPAQUE, abpe_pkg::ALPHA_OPAQUE, abpe_pkg::ALPHA_OPAQUE,
                    abpe_pkg::ALPHA_OPAQUE, abpe_pkg::GROUP_PIXELS, last);
        else
            g = grp(pick_alpha(), pick_alpha(), pick_alpha(), pick_alpha(),
                    abpe_pkg::GROUP_PIXELS, last);
        if (last)
        begin
            case ($urandom_range(9))
                6, 7:    g.pixel_count = 3'($urandom_range(1, 3));
                8:       g.pixel_count = 3'd0;
                9:       g.pixel_count = 3'($urandom_range(5, 7));
                default: g.pixel_count = abpe_pkg::GROUP_PIXELS;
            endcase
        end
        return g;
    endfunction

    task automatic add_image();
        int len;
        len = $urandom_range(1, 12);
        for (int k = 0; k < len; k++)
            pending_groups.push_back(random_group(k == len - 1));
        stim_count += len;
    endtask

    task automatic add_noise();
        pending_groups.push_back(grp(8'($urandom), 8'($urandom), 8'($urandom),
                                     8'($urandom), 3'($urandom_range(7)),
                                     1'($urandom_range(1))));
        stim_count++;
    endtask

    // Waits at falling edges so that the queues are seen after each clock update.
    task automatic wait_drained();
        while (pending_groups.size() != 0 || group_ch.valid || expected_bytes.size() != 0)
            @(negedge clk);
        // A group that makes no byte may still be inside the block.
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_palette(input logic [63:0] lo, input logic [63:0] hi);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= abpe_pkg::REG_PALETTE_LOW;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_index <= abpe_pkg::REG_PALETTE_HIGH;
        cfg_data  <= hi;
        @(posedge clk);
        cfg_we <= 1'b0;
        pal_lo = lo;
        pal_hi = hi;
        palettes_used++;
    endtask

    task automatic log_mismatch(input string field, input int got, input int want);
        $display("mismatch on byte %0d: %s is %0h, expected %0h",
                 bytes_checked, field, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin : drive_groups
        abpe_pkg::abpe_group_t g;
        if (!rst_n)
        begin
            group_ch.valid <= 1'b0;
        end
        else
        begin
            if (group_ch.valid && group_ch.ready)
            begin
                encode_group(grp(group_ch.pixel0, group_ch.pixel1, group_ch.pixel2,
                                 group_ch.pixel3, group_ch.pixel_count,
                                 group_ch.end_of_image));
                groups_accepted++;
            end
            if (!group_ch.valid || group_ch.ready)
            begin
                if (pending_groups.size() != 0 && !take_break())
                begin
                    g = pending_groups.pop_front();
                    group_ch.pixel0       <= g.pixel0;
                    group_ch.pixel1       <= g.pixel1;
                    group_ch.pixel2       <= g.pixel2;
                    group_ch.pixel3       <= g.pixel3;
                    group_ch.pixel_count  <= g.pixel_count;
                    group_ch.end_of_image <= g.end_of_image;
                    group_ch.valid        <= 1'b1;
                end
                else
                begin
                    group_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : check_bytes
        abpe_pkg::abpe_result_t want;
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    log_mismatch("unexpected byte", result_ch.data_byte, 0);
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (result_ch.stream_select !== want.stream_select)
                        log_mismatch("stream_select", result_ch.stream_select,
                                     want.stream_select);
                    if (result_ch.data_byte !== want.data_byte)
                        log_mismatch("data_byte", result_ch.data_byte, want.data_byte);
                    if (result_ch.palette_miss !== want.palette_miss)
                        log_mismatch("palette_miss", result_ch.palette_miss,
                                     want.palette_miss);
                    if (result_ch.run_last !== want.run_last)
                        log_mismatch("run_last", result_ch.run_last, want.run_last);
                    if (result_ch.image_last !== want.image_last)
                        log_mismatch("image_last", result_ch.image_last, want.image_last);
                    if (want.stream_select == abpe_pkg::STREAM_FLAG)
                        flag_bytes++;
                    if (want.palette_miss)
                        miss_bytes++;
                end
                bytes_checked++;
            end
            result_ch.ready <= !take_break();
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d bytes still expected",
                     cycle_count, expected_bytes.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        clk                    = 1'b0;
        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_index              = abpe_pkg::REG_PALETTE_LOW;
        cfg_data               = '0;
        group_ch.valid         = 1'b0;
        group_ch.pixel0        = '0;
        group_ch.pixel1        = '0;
        group_ch.pixel2        = '0;
        group_ch.pixel3        = '0;
        group_ch.pixel_count   = '0;
        group_ch.end_of_image  = 1'b0;
        result_ch.ready        = 1'b0;
        pal_lo                 = '0;
        pal_hi                 = '0;
        flag_bits              = '0;
        flag_count             = 0;
        steady                 = 1'b0;
        mismatches             = 0;
        cycle_count            = 0;
        groups_accepted        = 0;
        bytes_checked          = 0;
        flag_bytes             = 0;
        miss_bytes             = 0;
        palettes_used          = 0;
        stim_count             = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // The palette after reset holds zeros only, so only zero alpha hits.
        pending_groups.push_back(grp(8'h00, 8'h01, 8'hFF, 8'h00, 3'd4, 1'b0));
        pending_groups.push_back(grp(8'h00, 8'h00, 8'h00, 8'h00, 3'd4, 1'b0));
        pending_groups.push_back(grp(8'h00, 8'h80, 8'h00, 8'h00, 3'd2, 1'b1));
        wait_drained();

        // Entry 8 repeats entry 1, so a hit on that value must pick the lower index.
        write_palette(64'h7766_5544_3322_1100, 64'hFFEE_DDCC_BBAA_9911);
        pending_groups.push_back(grp(8'h00, 8'h00, 8'h00, 8'h00, 3'd4, 1'b0));
        pending_groups.push_back(grp(8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd4, 1'b0));
        pending_groups.push_back(grp(8'h11, 8'h22, 8'h33, 8'h44, 3'd4, 1'b0));
        pending_groups.push_back(grp(8'h00, 8'h11, 8'hFF, 8'h88, 3'd4, 1'b0));
        pending_groups.push_back(grp(8'h33, 8'h33, 8'h33, 8'h33, 3'd4, 1'b0));
        pending_groups.push_back(grp(8'h00, 8'h00, 8'h00, 8'h01, 3'd4, 1'b0));
        pending_groups.push_back(grp(8'hFF, 8'hFF, 8'hFF, 8'hFE, 3'd4, 1'b0));
        pending_groups.push_back(grp(8'h00, 8'h00, 8'h00, 8'h00, 3'd4, 1'b0));
        pending_groups.push_back(grp(8'h00, 8'h00, 8'h00, 8'h00, 3'd4, 1'b0));
        pending_groups.push_back(grp(8'h00, 8'h00, 8'h00, 8'h00, 3'd4, 1'b0));
        pending_groups.push_back(grp(8'h55, 8'h66, 8'h77, 8'h00, 3'd3, 1'b1));
        pending_groups.push_back(grp(8'h99, 8'h00, 8'h00, 8'h00, 3'd1, 1'b0));
        pending_groups.push_back(grp(8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 1'b1));
        pending_groups.push_back(grp(8'h00, 8'h00, 8'h00, 8'h00, 3'd4, 1'b0));
        pending_groups.push_back(grp(8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 1'b1));
        pending_groups.push_back(grp(8'hAA, 8'hBB, 8'hCC, 8'hDD, 3'd5, 1'b0));
        pending_groups.push_back(grp(8'hEE, 8'hFF, 8'h12, 8'h11, 3'd6, 1'b1));
        pending_groups.push_back(grp(8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd7, 1'b1));
        pending_groups.push_back(grp(8'h00, 8'h00, 8'h00, 8'h00, 3'd4, 1'b1));
        pending_groups.push_back(grp(8'h12, 8'h34, 8'h56, 8'h78, 3'd4, 1'b1));
        wait_drained();

        for (int p = 0; p < 5; p++)
        begin
            case (p)
                0: write_palette({$urandom, $urandom}, {$urandom, $urandom});
                1: write_palette('1, '1);
                2: write_palette(64'h0706_0504_0302_0100, 64'h0F0E_0D0C_0B0A_0908);
                3: write_palette('0, '0);
                default:
                begin
                    // The low half holds few distinct values, so entries repeat.
                    for (int b = 0; b < 8; b++)
                    begin
                        cfg_data[8*b +: 8] = 8'(85 * $urandom_range(3));
                    end
                    write_palette(cfg_data, {$urandom, $urandom} & 64'h5555_AAAA_FFFF_0000);
                end
            endcase
            // One phase runs with both sides always willing.
            steady     = (p == 2);
            stim_count = 0;
            while (stim_count < PHASE_ITEMS)
            begin
                if ($urandom_range(9) == 0)
                    add_noise();
                else
                    add_image();
            end
            wait_drained();
        end

        $display("Encoded %0d groups under %0d palette settings into %0d bytes:",
                 groups_accepted, palettes_used, bytes_checked);
        $display("%0d flag stream bytes, %0d index bytes with a palette miss.",
                 flag_bytes, miss_bytes);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/abpe_pkg.sv
rtl/abpe_group_if.sv
rtl/abpe_result_if.sv
rtl/abpe_group_encoder.sv
rtl/alpha_block_palette_encoder.sv
dv/alpha_block_palette_encoder_tb.sv
